// ===== hw/rtl/seconds_to_calendar_unit_assert.svh =====
// assertion macros for the seconds-to-calendar checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef SECONDS_TO_CALENDAR_UNIT_ASSERT_SVH
`define SECONDS_TO_CALENDAR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define S2C_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define S2C_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/s2cal_pkg.sv =====
// constants and the month-start table for the seconds-to-calendar pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package s2cal_pkg;

    localparam int unsigned EPOCH_W = 32;
    localparam int unsigned NUM_STAGES = 10;

    // floor(2^34 / 675), seconds are pre-shifted by 7 since 86400 = 128 * 675
    localparam logic [24:0] DAY_RECIP = 25'd25451658;
    localparam logic [9:0]  DAY_DIV   = 10'd675;

    // ceil(2^20 / 225), sod pre-shifted by 4 since 3600 = 16 * 225
    localparam logic [12:0] HOUR_RECIP = 13'd4661;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;

    // ceil(2^14 / 15), remainder pre-shifted by 2 since 60 = 4 * 15
    localparam logic [10:0] MIN_RECIP = 11'd1093;
    localparam logic [11:0] SECS_PER_MIN = 12'd60;

    // days from 2000-01-01 to the start of era five (2000-03-01)
    localparam logic [15:0] ERA5_START = 16'd60;
    // day of era four at 2000-01-01
    localparam logic [17:0] ERA4_OFFSET = 18'd146037;

    // ceil(2^24 / 365), used on doe / 4 for doe / 1460
    localparam logic [15:0] Q1460_RECIP = 16'd45965;
    // ceil(2^26 / 365), for year of era
    localparam logic [17:0] YEAR_RECIP = 18'd183860;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    localparam logic [17:0] CENT_DAYS_1 = 18'd36524;
    localparam logic [17:0] CENT_DAYS_2 = 18'd73048;
    localparam logic [17:0] CENT_DAYS_3 = 18'd109572;
    localparam logic [17:0] ERA_LAST_DAY = 18'd146096;

    // ceil(2^18 / 153), for the march-based month
    localparam logic [10:0] MONTH_RECIP = 11'd1714;

    localparam logic [11:0] YEAR_ERA4 = 12'd1600;
    localparam logic [11:0] YEAR_ERA5 = 12'd2000;

    // (153 * mp + 2) / 5: first day of each march-based month
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] res;
        unique case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/seconds_to_calendar_unit.sv =====
// seconds-since-2000 to time of day and gregorian date, ten-stage pipeline
// depends on s2cal_pkg
`timescale 1ns / 1ps
`default_nettype none

// Converts a 32-bit count of seconds since 2000-01-01 00:00:00 into hours,
// minutes, seconds, day, month and year. One word is taken every cycle unless
// stalled; a word passes stage 1 to the output register, and the stage count
// follows from the chain of constant-reciprocal multiplies (day split, era
// year, month), each followed by a register. When the output word is stalled
// the whole pipeline holds, so the input stall rises in that same cycle.
// No state is kept between words and every 32-bit input is valid.
module seconds_to_calendar_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [s2cal_pkg::EPOCH_W-1:0]   i_epoch_seconds,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [4:0]                           o_hours,
    output logic [5:0]                           o_minutes,
    output logic [5:0]                           o_seconds,
    output logic [4:0]                           o_day,
    output logic [3:0]                           o_month,
    output logic [11:0]                          o_year
);
    import s2cal_pkg::*;

    logic                  w_en;
    logic [NUM_STAGES-1:0] r_vld;

    // stage 1
    logic [49:0] r_s1_prod;
    logic [24:0] r_s1_a;
    logic [6:0]  r_s1_lo;
    // stage 2
    logic [15:0] r_s2_q;
    logic [10:0] r_s2_rem;
    logic [6:0]  r_s2_lo;
    logic [15:0] w_s2_q;
    logic [25:0] w_s2_rem;
    // stage 3
    logic [15:0] r_s3_days;
    logic [16:0] r_s3_sod;
    logic        w_s3_ge;
    logic [10:0] w_s3_r;
    // stage 4
    logic [17:0] r_s4_doe;
    logic        r_s4_era5;
    logic [16:0] r_s4_sod;
    logic [25:0] r_s4_ph;
    logic        w_s4_era5;
    // stage 5
    logic [31:0] r_s5_p1460;
    logic [17:0] r_s5_doe;
    logic        r_s5_era5;
    logic [4:0]  r_s5_hours;
    logic [11:0] r_s5_remh;
    logic [4:0]  w_s5_hours;
    logic [16:0] w_s5_remh;
    // stage 6
    logic [17:0] r_s6_t;
    logic [17:0] r_s6_doe;
    logic        r_s6_era5;
    logic [19:0] r_s6_pm;
    logic [4:0]  r_s6_hours;
    logic [11:0] r_s6_remh;
    logic [6:0]  w_s6_q1460;
    logic [2:0]  w_s6_qcent;
    logic        w_s6_last;
    // stage 7
    logic [34:0] r_s7_py;
    logic [17:0] r_s7_doe;
    logic        r_s7_era5;
    logic [4:0]  r_s7_hours;
    logic [5:0]  r_s7_min;
    logic [5:0]  r_s7_sec;
    logic [5:0]  w_s7_min;
    logic [11:0] w_s7_sec;
    // stage 8
    logic [8:0]  r_s8_doy;
    logic [8:0]  r_s8_yoe;
    logic        r_s8_era5;
    logic [4:0]  r_s8_hours;
    logic [5:0]  r_s8_min;
    logic [5:0]  r_s8_sec;
    logic [8:0]  w_s8_yoe;
    logic [1:0]  w_s8_y100;
    logic [17:0] w_s8_ydays;
    logic [17:0] w_s8_doy;
    // stage 9
    logic [21:0] r_s9_pmp;
    logic [8:0]  r_s9_doy;
    logic [8:0]  r_s9_yoe;
    logic        r_s9_era5;
    logic [4:0]  r_s9_hours;
    logic [5:0]  r_s9_min;
    logic [5:0]  r_s9_sec;
    logic [10:0] w_s9_v;
    // stage 10 (output register)
    logic [3:0]  w_s10_mp;
    logic [8:0]  w_s10_day;
    logic [3:0]  w_s10_month;
    logic [11:0] w_s10_year;
    logic [4:0]  r_out_hours;
    logic [5:0]  r_out_min;
    logic [5:0]  r_out_sec;
    logic [4:0]  r_out_day;
    logic [3:0]  r_out_month;
    logic [11:0] r_out_year;

    // whole pipeline advances unless the output word is held
    assign w_en    = !(r_vld[NUM_STAGES-1] && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_valid};
        end
    end

    // days = epoch / 86400 split as (epoch >> 7) / 675
    assign w_s2_q   = r_s1_prod[49:34];
    assign w_s2_rem = 26'(r_s1_a) - 26'(w_s2_q) * 26'(DAY_DIV);

    // estimate may be one low
    assign w_s3_ge = r_s2_rem >= 11'(DAY_DIV);
    assign w_s3_r  = w_s3_ge ? (r_s2_rem - 11'(DAY_DIV)) : r_s2_rem;

    assign w_s4_era5 = r_s3_days >= ERA5_START;

    assign w_s5_hours = r_s4_ph[24:20];
    assign w_s5_remh  = r_s4_sod - 17'(w_s5_hours) * SECS_PER_HOUR;

    assign w_s6_q1460 = r_s5_p1460[30:24];
    assign w_s6_qcent = 3'(r_s5_doe >= CENT_DAYS_1) + 3'(r_s5_doe >= CENT_DAYS_2)
                      + 3'(r_s5_doe >= CENT_DAYS_3) + 3'(r_s5_doe >= ERA_LAST_DAY);
    assign w_s6_last  = r_s5_doe == ERA_LAST_DAY;

    assign w_s7_min = r_s6_pm[19:14];
    assign w_s7_sec = r_s6_remh - 12'(w_s7_min) * SECS_PER_MIN;

    assign w_s8_yoe   = r_s7_py[34:26];
    assign w_s8_y100  = 2'(w_s8_yoe >= 9'd100) + 2'(w_s8_yoe >= 9'd200)
                      + 2'(w_s8_yoe >= 9'd300);
    assign w_s8_ydays = 18'(w_s8_yoe) * 18'(DAYS_PER_YEAR) + 18'(w_s8_yoe[8:2])
                      - 18'(w_s8_y100);
    assign w_s8_doy   = r_s7_doe - w_s8_ydays;

    // 5 * doy + 2
    assign w_s9_v = {r_s8_doy, 2'b00} + 11'(r_s8_doy) + 11'd2;

    assign w_s10_mp    = r_s9_pmp[21:18];
    assign w_s10_day   = r_s9_doy - month_start(w_s10_mp) + 9'd1;
    assign w_s10_month = (w_s10_mp < 4'd10) ? (w_s10_mp + 4'd3) : (w_s10_mp - 4'd9);
    assign w_s10_year  = (r_s9_era5 ? YEAR_ERA5 : YEAR_ERA4) + 12'(r_s9_yoe)
                       + 12'(w_s10_mp >= 4'd10);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_prod <= 50'(i_epoch_seconds[31:7]) * 50'(DAY_RECIP);
            r_s1_a    <= i_epoch_seconds[31:7];
            r_s1_lo   <= i_epoch_seconds[6:0];

            r_s2_q   <= w_s2_q;
            r_s2_rem <= w_s2_rem[10:0];
            r_s2_lo  <= r_s1_lo;

            r_s3_days <= r_s2_q + 16'(w_s3_ge);
            r_s3_sod  <= {w_s3_r[9:0], r_s2_lo};

            r_s4_doe  <= w_s4_era5 ? (18'(r_s3_days) - 18'(ERA5_START))
                                   : (18'(r_s3_days) + ERA4_OFFSET);
            r_s4_era5 <= w_s4_era5;
            r_s4_sod  <= r_s3_sod;
            r_s4_ph   <= 26'(r_s3_sod[16:4]) * 26'(HOUR_RECIP);

            r_s5_p1460 <= 32'(r_s4_doe[17:2]) * 32'(Q1460_RECIP);
            r_s5_doe   <= r_s4_doe;
            r_s5_era5  <= r_s4_era5;
            r_s5_hours <= w_s5_hours;
            r_s5_remh  <= w_s5_remh[11:0];

            r_s6_t     <= r_s5_doe - 18'(w_s6_q1460) + 18'(w_s6_qcent) - 18'(w_s6_last);
            r_s6_doe   <= r_s5_doe;
            r_s6_era5  <= r_s5_era5;
            r_s6_pm    <= 20'(r_s5_remh[11:2]) * 20'(MIN_RECIP);
            r_s6_hours <= r_s5_hours;
            r_s6_remh  <= r_s5_remh;

            r_s7_py    <= 35'(r_s6_t) * 35'(YEAR_RECIP);
            r_s7_doe   <= r_s6_doe;
            r_s7_era5  <= r_s6_era5;
            r_s7_hours <= r_s6_hours;
            r_s7_min   <= w_s7_min;
            r_s7_sec   <= w_s7_sec[5:0];

            r_s8_doy   <= w_s8_doy[8:0];
            r_s8_yoe   <= w_s8_yoe;
            r_s8_era5  <= r_s7_era5;
            r_s8_hours <= r_s7_hours;
            r_s8_min   <= r_s7_min;
            r_s8_sec   <= r_s7_sec;

            r_s9_pmp   <= 22'(w_s9_v) * 22'(MONTH_RECIP);
            r_s9_doy   <= r_s8_doy;
            r_s9_yoe   <= r_s8_yoe;
            r_s9_era5  <= r_s8_era5;
            r_s9_hours <= r_s8_hours;
            r_s9_min   <= r_s8_min;
            r_s9_sec   <= r_s8_sec;

            r_out_hours <= r_s9_hours;
            r_out_min   <= r_s9_min;
            r_out_sec   <= r_s9_sec;
            r_out_day   <= w_s10_day[4:0];
            r_out_month <= w_s10_month;
            r_out_year  <= w_s10_year;
        end
    end

    assign o_valid   = r_vld[NUM_STAGES-1];
    assign o_hours   = r_out_hours;
    assign o_minutes = r_out_min;
    assign o_seconds = r_out_sec;
    assign o_day     = r_out_day;
    assign o_month   = r_out_month;
    assign o_year    = r_out_year;

endmodule

`default_nettype wire

// ===== hw/rtl/s2cal_checker.sv =====
// port-level checks for seconds_to_calendar_unit, bound into every instance of it
// depends on seconds_to_calendar_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "seconds_to_calendar_unit_assert.svh"

module s2cal_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [4:0]  o_hours,
    input wire logic [5:0]  o_minutes,
    input wire logic [5:0]  o_seconds,
    input wire logic [4:0]  o_day,
    input wire logic [3:0]  o_month,
    input wire logic [11:0] o_year
);

    // a held output word keeps its fields
    `S2C_ASSERT_NXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_year) && $stable(o_month) && $stable(o_day)
        && $stable(o_hours) && $stable(o_minutes) && $stable(o_seconds),
        "stalled output word changed")

    // input back-pressure only while an output word is blocked
    `S2C_ASSERT_IMP(a_stall_cause, o_stall, o_valid && i_stall,
        "input stalled without blocked output")

    `S2C_ASSERT_IMP(a_time_range, o_valid,
        o_hours <= 5'd23 && o_minutes <= 6'd59 && o_seconds <= 6'd59,
        "time of day out of range")

    // month lengths, leap day only in leap years of this range
    `S2C_ASSERT_IMP(a_month_len, o_valid,
        o_day != 5'd0 && (o_month != 4'd2 || o_day <= 5'd29)
        && ((o_month != 4'd4 && o_month != 4'd6 && o_month != 4'd9 && o_month != 4'd11)
        || o_day <= 5'd30),
        "day outside its month")

    `S2C_ASSERT_IMP(a_leap_day, o_valid && o_month == 4'd2 && o_day == 5'd29,
        o_year[1:0] == 2'd0 && o_year != 12'd2100, "leap day in a common year")

endmodule

bind seconds_to_calendar_unit s2cal_checker u_s2cal_checker (.*);

`default_nettype wire

// ===== test/tb_seconds_to_calendar_unit.sv =====
// self-checking bench for seconds_to_calendar_unit: epoch words in, time/date words out
// depends on s2cal_pkg and seconds_to_calendar_unit; uses a small scoreboard class
`timescale 1ns / 1ps

module tb_seconds_to_calendar_unit;

    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_cal_word;

    localparam int unsigned SEND_COUNT = 650;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned LAST_FULL_DAY = 49709;

    class calendar_scoreboard;
        t_cal_word   pending_dates[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // time of day and gregorian date of an epoch word, civil-from-days era split
        function t_cal_word civil_date_of(logic [31:0] epoch);
            t_cal_word   res;
            int unsigned sod, days, z, era, doe, yoe, doy, mp, d, m, y;
            sod  = epoch % 32'd86400;
            days = epoch / 32'd86400 + 32'd10957;
            z    = days + 32'd719468;
            era  = z / 32'd146097;
            doe  = z - era * 32'd146097;
            yoe  = (doe - doe / 32'd1460 + doe / 32'd36524 - doe / 32'd146096) / 32'd365;
            doy  = doe - (32'd365 * yoe + yoe / 32'd4 - yoe / 32'd100);
            mp   = (32'd5 * doy + 32'd2) / 32'd153;
            d    = doy - (32'd153 * mp + 32'd2) / 32'd5 + 32'd1;
            m    = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
            y    = yoe + era * 32'd400 + ((m <= 32'd2) ? 32'd1 : 32'd0);
            res.hours   = 5'(sod / 32'd3600);
            res.minutes = 6'((sod % 32'd3600) / 32'd60);
            res.seconds = 6'(sod % 32'd60);
            res.day     = 5'(d);
            res.month   = 4'(m);
            res.year    = 12'(y);
            return res;
        endfunction

        function void note_epoch(logic [31:0] epoch);
            pending_dates.push_back(civil_date_of(epoch));
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_cal_word got);
            t_cal_word want;
            if (pending_dates.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual %p", $time, got);
                return;
            end
            want = pending_dates.pop_front();
            report("hours",   32'(want.hours),   32'(got.hours));
            report("minutes", 32'(want.minutes), 32'(got.minutes));
            report("seconds", 32'(want.seconds), 32'(got.seconds));
            report("day",     32'(want.day),     32'(got.day));
            report("month",   32'(want.month),   32'(got.month));
            report("year",    32'(want.year),    32'(got.year));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_epoch_seconds = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [4:0]  o_hours;
    logic [5:0]  o_minutes;
    logic [5:0]  o_seconds;
    logic [4:0]  o_day;
    logic [3:0]  o_month;
    logic [11:0] o_year;

    calendar_scoreboard sb;

    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;

    seconds_to_calendar_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hours         (o_hours),
        .o_minutes       (o_minutes),
        .o_seconds       (o_seconds),
        .o_day           (o_day),
        .o_month         (o_month),
        .o_year          (o_year)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: segments of free flow, sparse stalls, solid stalls and toggling
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = (stall_mode == 2) ? $urandom_range(1, 12) : $urandom_range(4, 60);
            end
            stall_left--;
            case (stall_mode)
                0: begin
                    i_stall <= 1'b0;
                end
                1: begin
                    i_stall <= ($urandom_range(0, 2) == 0);
                end
                2: begin
                    i_stall <= 1'b1;
                end
                default: begin
                    i_stall <= ~i_stall;
                end
            endcase
        end
    end

    // everything is driven at the rising edge, so values at the falling edge
    // are the ones the next rising edge sees
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_epoch(i_epoch_seconds);
            end
            if (o_valid && !i_stall) begin
                sb.check_result({o_hours, o_minutes, o_seconds, o_day, o_month, o_year});
            end
        end
    end

    function automatic logic [31:0] at_day(int unsigned days, int unsigned sod);
        longint unsigned total;
        total = longint'(days) * 86400 + sod;
        return total[31:0];
    endfunction

    function automatic logic [31:0] random_epoch();
        logic [31:0] res;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                res = $urandom;
            end
            5, 6: begin
                // within the full-day range, mostly near a day boundary
                case ($urandom_range(0, 3))
                    0: res = at_day($urandom_range(0, LAST_FULL_DAY), 0);
                    1: res = at_day($urandom_range(0, LAST_FULL_DAY), $urandom_range(0, 2));
                    2: res = at_day($urandom_range(0, LAST_FULL_DAY), 86399);
                    default: res = at_day($urandom_range(0, LAST_FULL_DAY),
                                          $urandom_range(0, 86399));
                endcase
            end
            7, 8: begin
                res = $urandom_range(0, 40000000);
            end
            default: begin
                res = 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
            end
        endcase
        return res;
    endfunction

    // call at a rising edge; returns at the edge that takes the word
    task automatic send_epoch(input logic [31:0] epoch);
        i_valid <= 1'b1;
        i_epoch_seconds <= epoch;
        @(negedge i_clk);
        while (o_stall) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int unsigned n);
        if (n > 0) begin
            i_valid <= 1'b0;
            i_epoch_seconds <= $urandom;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [31:0] corner_epochs[$];
        int unsigned sent;
        int unsigned burst_len;
        int unsigned gap;
        sb = new();
        corner_epochs = {32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
                         32'd86399, 32'd86400,
                         at_day(59, 43200),     // leap day in a leap century
                         at_day(60, 0),         // first of march after the leap day
                         at_day(365, 86399),    // end of the first year
                         at_day(366, 0),
                         at_day(424, 86399),    // end of february in a common year
                         at_day(425, 0),
                         at_day(36583, 86399),  // century year that is not leap
                         at_day(36584, 0),
                         at_day(38044, 0),      // first leap day after that century
                         32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                         32'hFFFF_FFFE, 32'hFFFF_FFFF};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (corner_epochs[k]) begin
            send_epoch(corner_epochs[k]);
            if (k % 6 == 5) begin
                idle_cycles($urandom_range(1, 3));
            end
        end
        idle_cycles(2);
        sent = 0;
        while (sent < SEND_COUNT) begin
            burst_len = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (burst_len) begin
                send_epoch(random_epoch());
                sent++;
            end
            idle_cycles(gap);
        end
        idle_cycles(1);
        while (sb.pending_dates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/s2cal_pkg.sv
hw/rtl/seconds_to_calendar_unit.sv
hw/rtl/s2cal_checker.sv
test/tb_seconds_to_calendar_unit.sv
